>>> rtl/core/sipw_pkg.sv
// Shared types, constants and the SipHash round function for the word hasher.
`default_nettype none
package sipw_pkg;

   typedef logic [63:0] lane_type;
   typedef lane_type [3:0] lanes_type;

   localparam lane_type IV0 = 64'h736f6d6570736575;
   localparam lane_type IV1 = 64'h646f72616e646f6d;
   localparam lane_type IV2 = 64'h6c7967656e657261;
   localparam lane_type IV3 = 64'h7465646279746573;
   localparam lane_type FINAL_MARK = 64'h00000000000000ff;

   localparam int CSR_INDEX_W = 4;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type REG_KEY_LOW         = 4'd0;
   localparam csr_index_type REG_KEY_HIGH        = 4'd1;
   localparam csr_index_type REG_COMPRESS_ROUNDS = 4'd2;
   localparam csr_index_type REG_FINAL_ROUNDS    = 4'd3;

   localparam logic CMD_ABSORB   = 1'b0;
   localparam logic CMD_FINALIZE = 1'b1;

   typedef logic [3:0] rounds_type;

   typedef struct packed {
      logic start;
      logic load_key;
      logic finalize;
      logic post_now;
      logic round;
      logic round_post;
      logic capture;
   } dp_cmd_type;

   function automatic lane_type rotl(input lane_type x, input int n);
      rotl = (x << n) | (x >> (64 - n));
   endfunction

   function automatic lanes_type sip_round(input lanes_type v);
      lanes_type r;
      r = v;
      r[0] = r[0] + r[1];
      r[2] = r[2] + r[3];
      r[1] = rotl(r[1], 13);
      r[3] = rotl(r[3], 16);
      r[1] = r[1] ^ r[0];
      r[3] = r[3] ^ r[2];
      r[0] = rotl(r[0], 32);
      r[2] = r[2] + r[1];
      r[0] = r[0] + r[3];
      r[1] = rotl(r[1], 17);
      r[3] = rotl(r[3], 21);
      r[1] = r[1] ^ r[2];
      r[3] = r[3] ^ r[0];
      r[2] = rotl(r[2], 32);
      sip_round = r;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/siphash_word_hasher_unit.sv
// Top level of the keyed SipHash word hasher: control registers, controller, datapath.
//
// Usage:
//   The req_ channel takes one item per handshake: req_cmd 0 absorbs req_word, req_cmd 1
//   finalizes the message and yields one rsp_ item carrying rsp_hash. A message is a run
//   of absorb items closed by a finalize item; the lanes load from the key on its first item.
//   csr_wr_en writes csr_wdata into the register at csr_index (0 key_low, 1 key_high,
//   2 compress_rounds, 3 final_rounds); other indexes are ignored. Write only while idle.
// Timing:
//   One SipHash round per cycle in the shared round unit. An absorb item runs its
//   compress_rounds rounds before the next item is accepted. A finalize item runs its
//   final_rounds rounds, then waits for a free output; the hash loads as rsp_valid rises,
//   and the next item can be taken once the hash has loaded.
// Reset:
//   Synchronous, active high: rounds return to 2 and 4, keys to zero, no result pending,
//   and the next item starts a new message.
// Stall:
//   A held result keeps rsp_hash steady; absorb items are still taken behind it, and a
//   following finalize waits before its hash is loaded.
`default_nettype none
module siphash_word_hasher_unit
   import sipw_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic          req_cmd,
   input  wire logic [63:0]   req_word,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic [63:0]        rsp_hash,
   input  wire logic          csr_wr_en,
   input  wire csr_index_type csr_index,
   input  wire logic [63:0]   csr_wdata
);

   lane_type   key_low_ff, key_low_in;
   lane_type   key_high_ff, key_high_in;
   rounds_type compress_rounds_ff, compress_rounds_in;
   rounds_type final_rounds_ff, final_rounds_in;
   dp_cmd_type dp_cmd;

   always_comb begin
      key_low_in         = key_low_ff;
      key_high_in        = key_high_ff;
      compress_rounds_in = compress_rounds_ff;
      final_rounds_in    = final_rounds_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_KEY_LOW:         key_low_in         = csr_wdata;
            REG_KEY_HIGH:        key_high_in        = csr_wdata;
            REG_COMPRESS_ROUNDS: compress_rounds_in = csr_wdata[3:0];
            REG_FINAL_ROUNDS:    final_rounds_in    = csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff         <= '0;
         key_high_ff        <= '0;
         compress_rounds_ff <= 4'd2;
         final_rounds_ff    <= 4'd4;
      end else begin
         key_low_ff         <= key_low_in;
         key_high_ff        <= key_high_in;
         compress_rounds_ff <= compress_rounds_in;
         final_rounds_ff    <= final_rounds_in;
      end
   end

   sipw_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_cmd         (req_cmd),
      .req_stall       (req_stall),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .compress_rounds (compress_rounds_ff),
      .final_rounds    (final_rounds_ff),
      .dp_cmd          (dp_cmd)
   );

   sipw_datapath u_datapath (
      .clock    (clock),
      .dp_cmd   (dp_cmd),
      .key_low  (key_low_ff),
      .key_high (key_high_ff),
      .word     (req_word),
      .hash     (rsp_hash)
   );

endmodule
`default_nettype wire

>>> rtl/core/sipw_datapath.sv
// Lane registers, round unit and hash output register of the word hasher.
`default_nettype none
module sipw_datapath
   import sipw_pkg::*;
(
   input  wire logic       clock,
   input  wire dp_cmd_type dp_cmd,
   input  wire lane_type   key_low,
   input  wire lane_type   key_high,
   input  wire lane_type   word,
   output lane_type        hash
);

   lanes_type lanes_ff, lanes_in;
   lane_type  word_ff, word_in;
   lane_type  hash_ff, hash_in;
   lanes_type base;
   lanes_type pre;
   lanes_type rnd;

   always_comb begin
      if (dp_cmd.load_key) begin
         base[0] = key_low ^ IV0;
         base[1] = key_high ^ IV1;
         base[2] = key_low ^ IV2;
         base[3] = key_high ^ IV3;
      end else begin
         base = lanes_ff;
      end
      pre = base;
      if (dp_cmd.finalize) begin
         pre[2] = pre[2] ^ FINAL_MARK;
      end else begin
         pre[3] = pre[3] ^ word;
      end
      if (dp_cmd.post_now) begin
         pre[0] = pre[0] ^ word;
      end
      rnd = sip_round(lanes_ff);
      if (dp_cmd.round_post) begin
         rnd[0] = rnd[0] ^ word_ff;
      end
      lanes_in = lanes_ff;
      word_in  = word_ff;
      if (dp_cmd.start) begin
         lanes_in = pre;
         word_in  = word;
      end else if (dp_cmd.round) begin
         lanes_in = rnd;
      end
      hash_in = hash_ff;
      if (dp_cmd.capture) begin
         hash_in = lanes_ff[0] ^ lanes_ff[1] ^ lanes_ff[2] ^ lanes_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      lanes_ff <= lanes_in;
      word_ff  <= word_in;
      hash_ff  <= hash_in;
   end

   assign hash = hash_ff;

endmodule
`default_nettype wire

>>> rtl/core/sipw_ctrl.sv
// Sequencing state machine of the word hasher: item handshake and round count.
`default_nettype none
module sipw_ctrl
   import sipw_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_cmd,
   output logic            req_stall,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   input  wire rounds_type compress_rounds,
   input  wire rounds_type final_rounds,
   output dp_cmd_type      dp_cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FINISH
   } state_type;

   state_type  state_ff, state_in;
   rounds_type count_ff, count_in;
   logic       fin_ff, fin_in;
   logic       fresh_ff, fresh_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_free;
   rounds_type rounds_sel;

   assign req_stall  = (state_ff != ST_IDLE);
   assign accept     = req_valid && !req_stall;
   assign out_free   = !(rsp_valid_ff && rsp_stall);
   assign rounds_sel = (req_cmd == CMD_FINALIZE) ? final_rounds : compress_rounds;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      fin_in       = fin_ff;
      fresh_in     = fresh_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      dp_cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               dp_cmd.start    = 1'b1;
               dp_cmd.load_key = fresh_ff;
               dp_cmd.finalize = (req_cmd == CMD_FINALIZE);
               dp_cmd.post_now = (req_cmd == CMD_ABSORB) && (rounds_sel == '0);
               fresh_in        = (req_cmd == CMD_FINALIZE);
               fin_in          = (req_cmd == CMD_FINALIZE);
               count_in        = rounds_sel;
               if (rounds_sel != '0) begin
                  state_in = ST_ROUND;
               end else if (req_cmd == CMD_FINALIZE) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_ROUND: begin
            dp_cmd.round = 1'b1;
            count_in     = count_ff - 4'd1;
            if (count_ff == 4'd1) begin
               dp_cmd.round_post = !fin_ff;
               state_in          = fin_ff ? ST_FINISH : ST_IDLE;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               dp_cmd.capture = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         fin_ff       <= 1'b0;
         fresh_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         fin_ff       <= fin_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_round_count_live: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND |-> count_ff != '0)
      else $error("round state entered with zero rounds left");
   a_finish_only_final: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH |-> fin_ff)
      else $error("finish state reached by an absorb item");
   a_capture_free: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.capture |-> out_free)
      else $error("hash captured over an unaccepted result");
   a_zero_absorb_idle: assert property (@(posedge clock) disable iff (reset)
      accept && req_cmd == CMD_ABSORB && compress_rounds == '0 |=> state_ff == ST_IDLE)
      else $error("zero-round absorb did not complete at once");
`endif

endmodule
`default_nettype wire
